// ===== design/wpcs_pkg.sv =====
// wpcs_pkg: shared types and constants of the white pixel centroid steering block
// used by the interfaces, the front, the frame queue, the back and the top level
package wpcs_pkg;

    localparam int RGB_W      = 8;
    localparam int COL_W      = 12;
    localparam int WIDTH_W    = 13;
    localparam int SUM_W      = 36;
    localparam int TALLY_W    = 25;
    localparam int DIR_W      = 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 13'd4096;
    localparam logic [WIDTH_W-1:0] RESET_WIDTH = 13'd640;
    localparam logic [TALLY_W-1:0] TALLY_MAX   = {TALLY_W{1'b1}};
    localparam logic [RGB_W-1:0]   CHAN_FULL   = 8'd255;

    // quotient of the mean never exceeds the highest column
    localparam int DIV_STEPS  = COL_W;
    localparam int STEP_W     = 4;

    // floor(x/3) as (x * ceil(2^17/3)) >> 17, exact for x below 2^16
    localparam int THIRD_SHIFT = 17;
    localparam logic [15:0] THIRD_RECIP = 16'd43691;
    localparam int PROD_W      = WIDTH_W + 1 + 16;

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH = 1'b0
    } wpcs_reg_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP    = 2'd0,
        DIR_LEFT    = 2'd1,
        DIR_FORWARD = 2'd2,
        DIR_RIGHT   = 2'd3
    } wpcs_dir_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_FINISH
    } wpcs_back_state_t;

    // totals of one finished frame, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [TALLY_W-1:0] tally;
        logic [WIDTH_W-1:0] width;
    } wpcs_frame_t;

endpackage

// ===== design/wpcs_if.sv =====
// wpcs_pixel_if and wpcs_result_if: valid/ready channels for pixels and results
// depends on wpcs_pkg for the field widths
interface wpcs_pixel_if
    import wpcs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] red;
    logic [RGB_W-1:0] green;
    logic [RGB_W-1:0] blue;
    logic             frame_end;

    modport source (output valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_end, output ready);
endinterface

interface wpcs_result_if
    import wpcs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DIR_W-1:0]   direction;
    logic [COL_W-1:0]   centroid_column;
    logic [TALLY_W-1:0] white_count;

    modport source (output valid, output direction, output centroid_column,
                    output white_count, input ready);
    modport sink   (input valid, input direction, input centroid_column,
                    input white_count, output ready);
endinterface

// ===== design/wpcs_front.sv =====
// wpcs_front: per-pixel column counter and white pixel sum and tally
// depends on wpcs_pkg and wpcs_pixel_if; pushes frame totals to the queue
module wpcs_front
    import wpcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WIDTH_W-1:0]  image_width,
    wpcs_pixel_if.sink          pixel,
    output logic                push_valid,
    input  logic                push_ready,
    output wpcs_frame_t         push_frame
);

    logic [COL_W-1:0]   col_reg,   col_next;
    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;

    logic [WIDTH_W-1:0] eff_width;
    logic [WIDTH_W-1:0] col_inc;
    logic               is_white;
    logic [SUM_W-1:0]   sum_acc;
    logic [TALLY_W-1:0] tally_acc;
    logic               accept;

    // clamp the width into one to the largest row
    always_comb
    begin
        if (image_width == '0)
            eff_width = WIDTH_W'(1);
        else if (image_width > MAX_WIDTH)
            eff_width = MAX_WIDTH;
        else
            eff_width = image_width;
    end

    // the queue only takes a frame's totals, so hold pixels whenever it is full
    assign pixel.ready = push_ready;
    assign accept      = pixel.valid && pixel.ready;

    // add the pixel's column when it is pure white and the tally has room
    always_comb
    begin
        col_inc   = {1'b0, col_reg} + WIDTH_W'(1);
        is_white  = (pixel.red == CHAN_FULL) && (pixel.green == CHAN_FULL)
                    && (pixel.blue == CHAN_FULL) && (tally_reg != TALLY_MAX);
        sum_acc   = is_white ? sum_reg + SUM_W'(col_reg) : sum_reg;
        tally_acc = is_white ? tally_reg + TALLY_W'(1) : tally_reg;
    end

    // next state: advance on each item, clear after the frame-end item
    always_comb
    begin
        col_next   = col_reg;
        sum_next   = sum_reg;
        tally_next = tally_reg;
        if (accept)
        begin
            if (pixel.frame_end)
            begin
                col_next   = '0;
                sum_next   = '0;
                tally_next = '0;
            end
            else
            begin
                col_next   = (col_inc >= eff_width) ? '0 : col_inc[COL_W-1:0];
                sum_next   = sum_acc;
                tally_next = tally_acc;
            end
        end
    end

    // frame totals including the frame-end pixel itself
    assign push_valid       = accept && pixel.frame_end;
    assign push_frame.sum   = sum_acc;
    assign push_frame.tally = tally_acc;
    assign push_frame.width = eff_width;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            sum_reg   <= '0;
            tally_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            sum_reg   <= sum_next;
            tally_reg <= tally_next;
        end
    end

endmodule

// ===== design/wpcs_queue.sv =====
// wpcs_queue: two-entry queue of frame totals between front and back
// depends on wpcs_pkg for the frame record type
module wpcs_queue
    import wpcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  wpcs_frame_t push_frame,
    output logic        pop_valid,
    input  logic        pop_ready,
    output wpcs_frame_t pop_frame
);

    wpcs_frame_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_frame  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

endmodule

// ===== design/wpcs_back.sv =====
// wpcs_back: per-frame mean by restoring division, thirds compare, result register
// depends on wpcs_pkg and wpcs_result_if; pops frame totals from the queue
module wpcs_back
    import wpcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  wpcs_frame_t pop_frame,
    wpcs_result_if.source result
);

    wpcs_back_state_t     state_reg, state_next;
    logic [STEP_W-1:0]    step_reg,  step_next;
    logic [TALLY_W-1:0]   rem_reg,   rem_next;
    logic [COL_W-1:0]     quot_reg,  quot_next;
    logic [TALLY_W-1:0]   tally_reg, tally_next;
    logic [COL_W-1:0]     lo_th_reg, lo_th_next;
    logic [COL_W-1:0]     hi_th_reg, hi_th_next;

    logic                 out_valid_reg, out_valid_next;
    wpcs_dir_t            dir_reg,   dir_next;
    logic [COL_W-1:0]     mean_reg,  mean_next;
    logic [TALLY_W-1:0]   count_reg, count_next;

    logic [TALLY_W:0]     part_rem;
    logic [TALLY_W:0]     trial;
    logic [PROD_W-1:0]    lo_prod, hi_prod;

    // one quotient bit per cycle; the remainder stays below the tally
    always_comb
    begin
        part_rem = {rem_reg, quot_reg[COL_W-1]};
        trial    = part_rem - {1'b0, tally_reg};
    end

    // floor(w/3) and floor(2w/3) by reciprocal multiply
    always_comb
    begin
        lo_prod = PROD_W'(pop_frame.width) * PROD_W'(THIRD_RECIP);
        hi_prod = PROD_W'({pop_frame.width, 1'b0}) * PROD_W'(THIRD_RECIP);
    end

    assign result.valid           = out_valid_reg;
    assign result.direction       = dir_reg;
    assign result.centroid_column = mean_reg;
    assign result.white_count     = count_reg;

    // sequencer: load a frame, divide, compare and post the result (stop if no white)
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        tally_next     = tally_reg;
        lo_th_next     = lo_th_reg;
        hi_th_next     = hi_th_reg;
        out_valid_next = out_valid_reg;
        dir_next       = dir_reg;
        mean_next      = mean_reg;
        count_next     = count_reg;
        pop_ready      = 1'b0;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            BACK_IDLE:
            begin
                if (pop_valid && !out_valid_reg)
                begin
                    pop_ready  = 1'b1;
                    tally_next = pop_frame.tally;
                    rem_next   = TALLY_W'(pop_frame.sum[SUM_W-1:COL_W]);
                    quot_next  = pop_frame.sum[COL_W-1:0];
                    lo_th_next = lo_prod[THIRD_SHIFT +: COL_W];
                    hi_th_next = hi_prod[THIRD_SHIFT +: COL_W];
                    step_next  = '0;
                    if (pop_frame.tally == '0)
                    begin
                        // no white pixel: stop at once
                        out_valid_next = 1'b1;
                        dir_next       = DIR_STOP;
                        mean_next      = '0;
                        count_next     = '0;
                    end
                    else
                    begin
                        state_next = BACK_DIV;
                    end
                end
            end
            BACK_DIV:
            begin
                if (trial[TALLY_W])
                begin
                    rem_next  = part_rem[TALLY_W-1:0];
                    quot_next = {quot_reg[COL_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next  = trial[TALLY_W-1:0];
                    quot_next = {quot_reg[COL_W-2:0], 1'b1};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = BACK_FINISH;
            end
            BACK_FINISH:
            begin
                out_valid_next = 1'b1;
                mean_next      = quot_reg;
                count_next     = tally_reg;
                if (quot_reg < lo_th_reg)
                    dir_next = DIR_LEFT;
                else if (quot_reg > hi_th_reg)
                    dir_next = DIR_RIGHT;
                else
                    dir_next = DIR_FORWARD;
                state_next = BACK_IDLE;
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        tally_reg <= tally_next;
        lo_th_reg <= lo_th_next;
        hi_th_reg <= hi_th_next;
        dir_reg   <= dir_next;
        mean_reg  <= mean_next;
        count_reg <= count_next;
    end

endmodule

// ===== design/white_pixel_centroid_steer.sv =====
// white_pixel_centroid_steer: top level, width register on the apb port
// depends on wpcs_pkg, wpcs_if, wpcs_front, wpcs_queue and wpcs_back
//
// Usage:
// pixels enter on the pixel channel (valid/ready) in raster order, one item
// per cycle, with frame_end high on the last pixel of each frame. Every item
// with frame_end yields one item on the result channel: direction (stop,
// left, forward, right), the mean white column and the white pixel count.
// image_width sits at byte address 0 of the apb port; write it only while
// the block is idle. It resets to 640.
// Throughput: one pixel per cycle while the queue has room. With the back
// free, a frame's totals go from the queue to the back's load, then through
// the 12 restoring division steps, the compare and the result hand-off; a
// frame with no white pixel goes from the load straight to the result.
// Up to two finished frames wait in the queue; pixels keep flowing while the
// back divides. If the receiver stalls, the result register holds, the queue
// fills and the pixel channel then drops ready until room returns.
// Reset clears the counters, the queue and any pending result.
module white_pixel_centroid_steer
    import wpcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    wpcs_pixel_if.sink        pixel,
    wpcs_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [WIDTH_W-1:0] image_width_reg, image_width_next;
    logic               cfg_write;
    logic               hit_width;

    logic               push_valid, push_ready;
    wpcs_frame_t        push_frame;
    logic               pop_valid,  pop_ready;
    wpcs_frame_t        pop_frame;

    // register decode
    assign pready    = 1'b1;
    assign hit_width = (paddr[ADDR_W-1:2] == REG_IMAGE_WIDTH);
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = hit_width ? DATA_W'(image_width_reg) : '0;

    always_comb
    begin
        image_width_next = image_width_reg;
        if (cfg_write && hit_width)
            image_width_next = pwdata[WIDTH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            image_width_reg <= RESET_WIDTH;
        else
            image_width_reg <= image_width_next;
    end

    wpcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_width (image_width_reg),
        .pixel       (pixel),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_frame  (push_frame)
    );

    wpcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    wpcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_frame (pop_frame),
        .result    (result)
    );

endmodule

// ===== test/white_pixel_centroid_steer_test.sv =====
// white_pixel_centroid_steer_test: self-checking bench for the white pixel centroid steering block
// drives pixel frames and width writes, predicts each frame's steering result and compares
// depends on wpcs_pkg, wpcs_if and white_pixel_centroid_steer
`timescale 1ns / 100ps

module white_pixel_centroid_steer_test
    import wpcs_pkg::*;
;

    localparam int HALF_PERIOD = 10;
    localparam int IDLE_PCT    = 29;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 95;
    localparam logic [ADDR_W-1:0] WIDTH_ADDR = ADDR_W'(4 * int'(REG_IMAGE_WIDTH));

    typedef struct packed {
        logic [RGB_W-1:0] red;
        logic [RGB_W-1:0] green;
        logic [RGB_W-1:0] blue;
        logic             frame_end;
    } pixel_item_t;

    typedef struct {
        wpcs_dir_t          direction;
        logic [COL_W-1:0]   column;
        logic [TALLY_W-1:0] count;
    } steer_t;

    // clock, reset and driven inputs, all known from time zero
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic [RGB_W-1:0] pix_red = '0;
    logic [RGB_W-1:0] pix_green = '0;
    logic [RGB_W-1:0] pix_blue = '0;
    logic pix_frame_end = 1'b0;
    logic res_ready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    wpcs_pixel_if  pixel_ch ();
    wpcs_result_if result_ch ();

    assign pixel_ch.valid     = pix_valid;
    assign pixel_ch.red       = pix_red;
    assign pixel_ch.green     = pix_green;
    assign pixel_ch.blue      = pix_blue;
    assign pixel_ch.frame_end = pix_frame_end;
    assign result_ch.ready    = res_ready;

    white_pixel_centroid_steer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pixels waiting to be offered and steering results still owed
    pixel_item_t pending_pixels[$];
    steer_t      steer_due[$];

    // predictor copy of the width register and the frame accumulators
    logic [WIDTH_W-1:0] width_reg = RESET_WIDTH;
    logic [COL_W-1:0]   col_pos = '0;
    logic [SUM_W-1:0]   col_sum = '0;
    logic [TALLY_W-1:0] tally = '0;

    // handshakes between processes
    logic pixel_fired = 1'b0;
    logic steady = 1'b0;
    int   stall_asked = 0;
    int   stall_served = 0;
    int   hold_left = 0;

    int error_count = 0;
    int pixels_sent = 0;
    int frames_checked = 0;
    int widths_used = 0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // clamp a written width to the range the block works with
    function automatic logic [WIDTH_W-1:0] working_width(input logic [WIDTH_W-1:0] w);
        if (w == '0)
            return WIDTH_W'(1);
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return w;
    endfunction

    // advance the accumulators by one accepted pixel, queue a result on frame end
    task automatic track_pixel(input pixel_item_t px);
        logic [WIDTH_W-1:0] w;
        logic [SUM_W-1:0]   mean;
        int                 mean_col;
        steer_t             res;
        w = working_width(width_reg);
        if (px.red == CHAN_FULL && px.green == CHAN_FULL && px.blue == CHAN_FULL
            && tally != TALLY_MAX)
        begin
            col_sum = col_sum + SUM_W'(col_pos);
            tally = tally + TALLY_W'(1);
        end
        if (int'(col_pos) + 1 >= int'(w))
            col_pos = '0;
        else
            col_pos = col_pos + COL_W'(1);
        if (px.frame_end)
        begin
            res.direction = DIR_STOP;
            mean = '0;
            if (tally != '0)
            begin
                mean = col_sum / SUM_W'(tally);
                mean_col = int'(mean);
                if (mean_col < int'(w) / 3)
                    res.direction = DIR_LEFT;
                else if (mean_col > (int'(w) * 2) / 3)
                    res.direction = DIR_RIGHT;
                else
                    res.direction = DIR_FORWARD;
            end
            res.column = mean[COL_W-1:0];
            res.count = tally;
            steer_due.push_back(res);
            col_pos = '0;
            col_sum = '0;
            tally = '0;
        end
    endtask

    // pixel driver: next item at the falling edge once the current one is taken
    always @(negedge clk)
    begin : drive_pixels
        pixel_item_t next_pixel;
        if (rst_n && (!pix_valid || pixel_fired))
        begin
            if (pending_pixels.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                next_pixel = pending_pixels.pop_front();
                pix_valid <= 1'b1;
                pix_red <= next_pixel.red;
                pix_green <= next_pixel.green;
                pix_blue <= next_pixel.blue;
                pix_frame_end <= next_pixel.frame_end;
            end
            else
            begin
                pix_valid <= 1'b0;
            end
        end
    end

    // result ready: random stalls, or a long hold-off when one is asked for
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_ready <= 1'b0;
        end
        else if (stall_asked != stall_served)
        begin
            stall_served = stall_asked;
            hold_left = HOLD_CYCLES;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: check results against the oldest expectation, then predict from accepted pixels
    always @(posedge clk)
    begin : watch_channels
        steer_t due;
        pixel_item_t taken;
        if (rst_n)
        begin
            if (result_ch.valid && res_ready)
            begin
                if (steer_due.size() == 0)
                begin
                    $display("%0t: result with none expected: direction %0d column %0d count %0d",
                             $time, result_ch.direction, result_ch.centroid_column,
                             result_ch.white_count);
                    error_count++;
                end
                else
                begin
                    due = steer_due.pop_front();
                    frames_checked++;
                    if (result_ch.direction !== due.direction)
                    begin
                        $display("%0t: direction expected %0d got %0d",
                                 $time, due.direction, result_ch.direction);
                        error_count++;
                    end
                    if (result_ch.centroid_column !== due.column)
                    begin
                        $display("%0t: centroid_column expected %0d got %0d",
                                 $time, due.column, result_ch.centroid_column);
                        error_count++;
                    end
                    if (result_ch.white_count !== due.count)
                    begin
                        $display("%0t: white_count expected %0d got %0d",
                                 $time, due.count, result_ch.white_count);
                        error_count++;
                    end
                end
            end
            pixel_fired = pix_valid && pixel_ch.ready;
            if (pixel_fired)
            begin
                taken.red = pix_red;
                taken.green = pix_green;
                taken.blue = pix_blue;
                taken.frame_end = pix_frame_end;
                track_pixel(taken);
                pixels_sent++;
            end
        end
    end

    task automatic push_pixel(input logic [RGB_W-1:0] r, input logic [RGB_W-1:0] g,
                              input logic [RGB_W-1:0] b, input logic fe);
        pixel_item_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        px.frame_end = fe;
        pending_pixels.push_back(px);
    endtask

    // width write over the apb port: setup cycle, then access cycle
    task automatic write_width(input logic [WIDTH_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= WIDTH_ADDR;
        pwdata <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        width_reg = value;
        widths_used++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait until every pixel is taken, every result is in and the back has settled
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || pix_valid)
            @(posedge clk);
        while (steer_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random pixel, usually non-white, often only one channel short of white
    function automatic pixel_item_t noise_pixel();
        pixel_item_t px;
        px.red = RGB_W'($urandom);
        px.green = RGB_W'($urandom);
        px.blue = RGB_W'($urandom);
        px.frame_end = 1'b0;
        case ($urandom_range(0, 3))
            1:
            begin
                px.red = CHAN_FULL;
                px.green = CHAN_FULL;
            end
            2:
            begin
                px.green = CHAN_FULL;
                px.blue = CHAN_FULL;
            end
            3:
            begin
                px.red = CHAN_FULL;
                px.blue = CHAN_FULL;
            end
            default: ;
        endcase
        return px;
    endfunction

    // frames of whole rows mostly at narrow widths, else of ragged length, with varied white patterns
    task automatic build_frames(input int n_items, input logic [WIDTH_W-1:0] w);
        int ew;
        int len;
        int mode;
        int col;
        int added;
        bit white;
        pixel_item_t px;
        ew = int'(working_width(w));
        added = 0;
        while (added < n_items)
        begin
            if (ew <= 64 && $urandom_range(0, 9) < 8)
                len = ew * $urandom_range(1, 4);
            else
                len = $urandom_range(1, 90);
            mode = $urandom_range(0, 5);
            for (int i = 0; i < len; i++)
            begin
                col = i % ew;
                case (mode)
                    0: white = 1'b0;
                    1: white = $urandom_range(0, 99) < 8;
                    2: white = $urandom_range(0, 99) < 60;
                    3: white = 1'b1;
                    4: white = (col >= ew / 2) && $urandom_range(0, 1);
                    default: white = (col < (ew + 2) / 3) && $urandom_range(0, 1);
                endcase
                if (white)
                begin
                    px.red = CHAN_FULL;
                    px.green = CHAN_FULL;
                    px.blue = CHAN_FULL;
                end
                else
                begin
                    px = noise_pixel();
                end
                px.frame_end = (i == len - 1);
                pending_pixels.push_back(px);
            end
            added += len;
        end
        // sometimes leave a frame open so the next width lands mid-frame
        if ($urandom_range(0, 1))
        begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
            begin
                px = noise_pixel();
                if ($urandom_range(0, 1))
                begin
                    px.red = CHAN_FULL;
                    px.green = CHAN_FULL;
                    px.blue = CHAN_FULL;
                end
                pending_pixels.push_back(px);
            end
        end
    endtask

    // stimulus sequence and final verdict
    initial
    begin : run_sequence
        logic [WIDTH_W-1:0] phase_widths[$];
        phase_widths = '{13'd2, 13'd1, 13'd0, 13'd3, 13'd5, 13'd8, 13'd17, 13'd64,
                         13'd640, 13'd4096, 13'd4097, 13'd8191};
        phase_widths.push_back(WIDTH_W'($urandom_range(1, 300)));
        phase_widths.push_back(WIDTH_W'($urandom_range(1, 8191)));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed at the reset width: empty frame, lone white, near-white only
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd254, 1'b0);
        push_pixel(8'd254, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd255, 8'd254, 8'd255, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        wait_idle();

        // directed at width four: right, forward on a lone column, forward on averages
        write_width(13'd4);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd128, 8'd64, 8'd32, 1'b0);
        push_pixel(8'd127, 8'd191, 8'd223, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        wait_idle();

        // random phases over the width settings
        foreach (phase_widths[p])
        begin
            write_width(phase_widths[p]);
            if (p == 0)
                stall_asked++;
            steady = (p == 4);
            build_frames(PHASE_ITEMS, phase_widths[p]);
            wait_idle();
            steady = 1'b0;
        end

        $display("covered %0d pixels and %0d frame results over %0d width settings",
                 pixels_sent, frames_checked, widths_used);
        $display("including a long receiver hold-off, clamped widths and mid-frame width changes");
        if (error_count == 0)
            $display("white_pixel_centroid_steer_test passed");
        else
            $display("white_pixel_centroid_steer_test failed");
        $finish;
    end

    // overall time limit
    initial
    begin
        #12_000_000;
        $display("timeout with %0d results still owed", steer_due.size());
        $display("white_pixel_centroid_steer_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/wpcs_pkg.sv
design/wpcs_if.sv
design/wpcs_front.sv
design/wpcs_queue.sv
design/wpcs_back.sv
design/white_pixel_centroid_steer.sv
test/white_pixel_centroid_steer_test.sv
